### rtl/teq_pkg.sv
package teq_pkg;

   localparam int TIME_BITS   = 32;
   localparam int FIELD_ID_BITS = 16;
   localparam int MAX_RESULTS = 16;
   localparam int RESULT_BITS = 5;

   localparam logic [2:0] OP_ADD       = 3'd0;
   localparam logic [2:0] OP_REMOVE    = 3'd1;
   localparam logic [2:0] OP_REPORT_AT = 3'd2;
   localparam logic [2:0] OP_PENDING   = 3'd3;
   localparam logic [2:0] OP_ADVANCE   = 3'd4;

   localparam logic STATUS_REPORT = 1'b0;
   localparam logic STATUS_FULL   = 1'b1;

   typedef struct packed {
      logic [2:0]               operation;
      logic [TIME_BITS-1:0]     time_value;
      logic [FIELD_ID_BITS-1:0] event_id;
   } req_type;

   typedef struct packed {
      logic                     status;
      logic [TIME_BITS-1:0]     due_time;
      logic [FIELD_ID_BITS-1:0] reported_id;
      logic                     last;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DELETE,
      ST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_ROTATE,
      CELL_DELETE
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type        mode;
      logic [TIME_BITS-1:0] key_time;
      logic                 del_eq;
   } cell_ctrl_type;

endpackage

### rtl/teq_cell.sv
module teq_cell #(
   parameter int IDX = 0,
   parameter int CW  = 5,
   parameter int SID = 16
) (
   input  logic                           clock,
   input  teq_pkg::cell_ctrl_type         ctrl,
   input  logic [CW-1:0]                  count,
   input  logic [SID-1:0]                 new_id,
   input  logic [teq_pkg::TIME_BITS-1:0]  left_time,
   input  logic [SID-1:0]                 left_id,
   input  logic                           left_gt,
   input  logic [teq_pkg::TIME_BITS-1:0]  right_time,
   input  logic [SID-1:0]                 right_id,
   input  logic [teq_pkg::TIME_BITS-1:0]  head_time,
   input  logic [SID-1:0]                 head_id,
   input  logic                           kill_in,
   output logic [teq_pkg::TIME_BITS-1:0]  time_q,
   output logic [SID-1:0]                 id_q,
   output logic                           gt,
   output logic                           kill_out
);

   logic [teq_pkg::TIME_BITS-1:0] time_ff, time_in;
   logic [SID-1:0]                id_ff, id_in;
   logic                          occ;
   logic                          kill;

   assign occ      = CW'(IDX) < count;
   assign gt       = occ && (time_ff > ctrl.key_time);
   assign kill     = occ && (ctrl.del_eq ? (time_ff == ctrl.key_time)
                                         : (time_ff < ctrl.key_time));
   assign kill_out = kill_in || kill;
   assign time_q   = time_ff;
   assign id_q     = id_ff;

   always_comb begin
      time_in = time_ff;
      id_in   = id_ff;
      case (ctrl.mode)
         teq_pkg::CELL_INSERT: begin
            // entries after the insertion point move one place down the row
            if (left_gt) begin
               time_in = left_time;
               id_in   = left_id;
            end else if (gt || (CW'(IDX) == count)) begin
               time_in = ctrl.key_time;
               id_in   = new_id;
            end
         end
         teq_pkg::CELL_ROTATE: begin
            // the tail of the occupied run takes the head back
            if (CW'(IDX + 1) == count) begin
               time_in = head_time;
               id_in   = head_id;
            end else if (CW'(IDX + 1) < count) begin
               time_in = right_time;
               id_in   = right_id;
            end
         end
         teq_pkg::CELL_DELETE: begin
            if (kill_out) begin
               time_in = right_time;
               id_in   = right_id;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      time_ff <= time_in;
      id_ff   <= id_in;
   end

endmodule

### rtl/teq_chain.sv
module teq_chain #(
   parameter int DEPTH = 16,
   parameter int CW    = 5,
   parameter int SID   = 16
) (
   input  logic                           clock,
   input  teq_pkg::cell_ctrl_type         ctrl,
   input  logic [CW-1:0]                  count,
   input  logic [SID-1:0]                 new_id,
   output logic [teq_pkg::TIME_BITS-1:0]  head_time,
   output logic [SID-1:0]                 head_id,
   output logic                           any_kill
);

   logic [teq_pkg::TIME_BITS-1:0] cell_time [DEPTH+1];
   logic [SID-1:0]                cell_id   [DEPTH+1];
   logic                          cell_gt   [DEPTH];
   logic                          kill_pre  [DEPTH+1];

   assign kill_pre[0]      = 1'b0;
   assign cell_time[DEPTH] = '0;
   assign cell_id[DEPTH]   = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [teq_pkg::TIME_BITS-1:0] l_time;
      logic [SID-1:0]                l_id;
      logic                          l_gt;

      if (i == 0) begin : g_first
         assign l_time = '0;
         assign l_id   = '0;
         assign l_gt   = 1'b0;
      end else begin : g_rest
         assign l_time = cell_time[i-1];
         assign l_id   = cell_id[i-1];
         assign l_gt   = cell_gt[i-1];
      end

      teq_cell #(
         .IDX (i),
         .CW  (CW),
         .SID (SID)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count),
         .new_id     (new_id),
         .left_time  (l_time),
         .left_id    (l_id),
         .left_gt    (l_gt),
         .right_time (cell_time[i+1]),
         .right_id   (cell_id[i+1]),
         .head_time  (cell_time[0]),
         .head_id    (cell_id[0]),
         .kill_in    (kill_pre[i]),
         .time_q     (cell_time[i]),
         .id_q       (cell_id[i]),
         .gt         (cell_gt[i]),
         .kill_out   (kill_pre[i+1])
      );
   end

   assign head_time = cell_time[0];
   assign head_id   = cell_id[0];
   assign any_kill  = kill_pre[DEPTH];

endmodule

### rtl/timed_event_queue_core.sv
// A successful add inserts its entry in place and gives no beat; a full add holds a
// FULL beat that the flush state moves to the output register. Reports and advance
// rotate the occupied cells past the head, one per cycle unless a held beat cannot
// move on; remove and advance delete one entry per cycle until none matches. The flush
// state sends the last held beat, if any, marked last. Requests wait while not idle.
// Reset (synchronous): empties the queue, zeroes the time; cell data stays undefined.
module timed_event_queue_core #(
   parameter int QUEUE_DEPTH = 16,
   parameter int ID_BITS     = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  teq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output teq_pkg::rsp_type rsp_data
);

   localparam int CW  = $clog2(QUEUE_DEPTH + 1);
   localparam int SID = (ID_BITS < teq_pkg::FIELD_ID_BITS) ? ID_BITS
                                                           : teq_pkg::FIELD_ID_BITS;

   teq_pkg::state_type            state_ff, state_in;
   logic [CW-1:0]                 count_ff, count_in;
   logic [CW-1:0]                 step_ff, step_in;
   logic [teq_pkg::RESULT_BITS-1:0] nres_ff, nres_in;
   logic [teq_pkg::TIME_BITS-1:0] cur_time_ff, cur_time_in;
   logic [2:0]                    op_ff, op_in;
   logic [teq_pkg::TIME_BITS-1:0] tv_ff, tv_in;
   logic [teq_pkg::TIME_BITS-1:0] lo_ff, lo_in;
   logic [teq_pkg::TIME_BITS-1:0] hi_ff, hi_in;
   logic                          pend_valid_ff, pend_valid_in;
   teq_pkg::rsp_type              pend_ff, pend_in;
   logic                          out_valid_ff, out_valid_in;
   teq_pkg::rsp_type              out_ff, out_in;

   teq_pkg::cell_ctrl_type        ctrl;
   logic [teq_pkg::TIME_BITS-1:0] head_time;
   logic [SID-1:0]                head_id;
   logic [SID-1:0]                new_id;
   logic                          any_kill;

   logic accept;
   logic full;
   logic hit;
   logic capture;
   logic out_free;
   logic scan_go;
   logic last_step;

   assign new_id    = req_data.event_id[SID-1:0];
   assign full      = count_ff == CW'(QUEUE_DEPTH);
   assign req_stall = state_ff != teq_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign last_step = CW'(step_ff + 1'b1) == count_ff;

   always_comb begin
      case (op_ff)
         teq_pkg::OP_REPORT_AT: hit = head_time == tv_ff;
         teq_pkg::OP_PENDING:   hit = head_time > lo_ff;
         teq_pkg::OP_ADVANCE:   hit = (head_time > lo_ff) && (head_time <= hi_ff);
         default:               hit = 1'b0;
      endcase
   end

   assign capture = (state_ff == teq_pkg::ST_SCAN) && hit
                    && (nres_ff < teq_pkg::RESULT_BITS'(teq_pkg::MAX_RESULTS));
   // hold the rotation while a held beat cannot move to the output register
   assign scan_go = (state_ff == teq_pkg::ST_SCAN)
                    && !(capture && pend_valid_ff && !out_free);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_data.operation) inside
                  teq_pkg::OP_ADD:
                     if (full) state_in = teq_pkg::ST_FLUSH;
                  teq_pkg::OP_REMOVE:
                     state_in = teq_pkg::ST_DELETE;
                  teq_pkg::OP_REPORT_AT, teq_pkg::OP_PENDING, teq_pkg::OP_ADVANCE: begin
                     if (count_ff != '0)
                        state_in = teq_pkg::ST_SCAN;
                     else if (req_data.operation == teq_pkg::OP_ADVANCE)
                        state_in = teq_pkg::ST_DELETE;
                     else
                        state_in = teq_pkg::ST_FLUSH;
                  end
                  default: state_in = teq_pkg::ST_IDLE;
               endcase
            end
         end
         teq_pkg::ST_SCAN: begin
            if (scan_go && last_step)
               state_in = (op_ff == teq_pkg::OP_ADVANCE) ? teq_pkg::ST_DELETE
                                                         : teq_pkg::ST_FLUSH;
         end
         teq_pkg::ST_DELETE: begin
            if (!any_kill) state_in = teq_pkg::ST_FLUSH;
         end
         teq_pkg::ST_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = teq_pkg::ST_IDLE;
         end
         default: state_in = teq_pkg::ST_IDLE;
      endcase
   end

   // cell control
   always_comb begin
      ctrl.mode     = teq_pkg::CELL_HOLD;
      ctrl.key_time = req_data.time_value;
      ctrl.del_eq   = 1'b0;
      case (state_ff)
         teq_pkg::ST_IDLE: begin
            if (accept && (req_data.operation == teq_pkg::OP_ADD) && !full)
               ctrl.mode = teq_pkg::CELL_INSERT;
         end
         teq_pkg::ST_SCAN: begin
            if (scan_go) ctrl.mode = teq_pkg::CELL_ROTATE;
         end
         teq_pkg::ST_DELETE: begin
            ctrl.mode     = teq_pkg::CELL_DELETE;
            ctrl.del_eq   = op_ff == teq_pkg::OP_REMOVE;
            ctrl.key_time = (op_ff == teq_pkg::OP_REMOVE) ? tv_ff : lo_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath and counters
   always_comb begin
      count_in      = count_ff;
      step_in       = step_ff;
      nres_in       = nres_ff;
      cur_time_in   = cur_time_ff;
      op_in         = op_ff;
      tv_in         = tv_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_in        = out_ff;

      if (ctrl.mode == teq_pkg::CELL_INSERT)
         count_in = count_ff + 1'b1;
      if ((state_ff == teq_pkg::ST_DELETE) && any_kill)
         count_in = count_ff - 1'b1;

      if (state_ff == teq_pkg::ST_IDLE) begin
         step_in = '0;
         nres_in = '0;
      end

      if (accept) begin
         op_in = req_data.operation;
         tv_in = req_data.time_value;
         lo_in = cur_time_ff;
         hi_in = cur_time_ff + req_data.time_value;
         if (req_data.operation == teq_pkg::OP_ADVANCE)
            cur_time_in = cur_time_ff + req_data.time_value;
         if ((req_data.operation == teq_pkg::OP_ADD) && full) begin
            pend_valid_in       = 1'b1;
            pend_in.status      = teq_pkg::STATUS_FULL;
            pend_in.due_time    = req_data.time_value;
            pend_in.reported_id = teq_pkg::FIELD_ID_BITS'(new_id);
            pend_in.last        = 1'b0;
         end
      end

      if (scan_go) begin
         step_in = step_ff + 1'b1;
         if (capture) begin
            nres_in = nres_ff + 1'b1;
            // hand the held beat on, then hold the new one
            if (pend_valid_ff) begin
               out_valid_in = 1'b1;
               out_in       = pend_ff;
            end
            pend_valid_in       = 1'b1;
            pend_in.status      = teq_pkg::STATUS_REPORT;
            pend_in.due_time    = head_time;
            pend_in.reported_id = teq_pkg::FIELD_ID_BITS'(head_id);
            pend_in.last        = 1'b0;
         end
      end

      if ((state_ff == teq_pkg::ST_FLUSH) && pend_valid_ff && out_free) begin
         pend_valid_in = 1'b0;
         out_valid_in  = 1'b1;
         out_in        = pend_ff;
         out_in.last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= teq_pkg::ST_IDLE;
         count_ff      <= '0;
         step_ff       <= '0;
         nres_ff       <= '0;
         cur_time_ff   <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         step_ff       <= step_in;
         nres_ff       <= nres_in;
         cur_time_ff   <= cur_time_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      op_ff   <= op_in;
      tv_ff   <= tv_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   teq_chain #(
      .DEPTH (QUEUE_DEPTH),
      .CW    (CW),
      .SID   (SID)
   ) u_chain (
      .clock     (clock),
      .ctrl      (ctrl),
      .count     (count_ff),
      .new_id    (new_id),
      .head_time (head_time),
      .head_id   (head_id),
      .any_kill  (any_kill)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule
